@@ design/line_pixel_generator_assert.svh @@
// ---------------------------------------------------------------------------
// line_pixel_generator_assert.svh
// Assertion macros shared by the line pixel generator modules.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpg: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpg: next-cycle check failed");

`endif

@@ design/lpg_pkg.sv @@
// ---------------------------------------------------------------------------
// lpg_pkg
// Shared types, constants and the pixel byte packer of the line generator.
// ---------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FIFO_DEPTH_DEF = 2;

    // register reset values
    localparam logic [31:0] FRAME_BASE_RST = 32'd0;
    localparam logic [15:0] LINE_BYTES_RST = 16'd4800;
    localparam logic [5:0]  BPP_RST        = 6'd32;
    localparam logic        BIG_ENDIAN_RST = 1'b0;

    localparam logic [7:0]  BYTE_MASK      = 8'hFF;

    typedef enum logic [1:0] {
        REG_FRAME_BASE = 2'd0,
        REG_LINE_BYTES = 2'd1,
        REG_BPP        = 2'd2,
        REG_BIG_ENDIAN = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // configuration seen by the address/packing side
    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_bytes;
        logic [5:0]  bits_per_pixel;
        logic        big_endian;
    } t_cfg;

    // colour bytes in write order, first written byte in bits 7:0
    function automatic logic [31:0] pack_pixel(input logic [31:0] color,
                                               input logic [5:0]  bpp,
                                               input logic        big);
        logic [2:0]  n;
        logic [2:0]  idx;
        logic [31:0] word;
        n    = bpp[5:3];
        word = '0;
        for (int k = 0; k < 4; k++) begin
            idx = big ? 3'(n - 3'(k + 1)) : 3'(k);
            // bytes past the pixel size, or above the colour word, are zero
            if ((3'(k) < n) && (idx < 3'd4)) begin
                word[8*k +: 8] = color[{idx[1:0], 3'b000} +: 8] & BYTE_MASK;
            end
        end
        return word;
    endfunction

endpackage

@@ design/lpg_fifo.sv @@
// ---------------------------------------------------------------------------
// lpg_fifo
// Short pixel queue between the stepping front and the addressing back.
// ---------------------------------------------------------------------------
`include "line_pixel_generator_assert.svh"

module lpg_fifo import lpg_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `LPG_ASSERT_NXT(a_fill_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `LPG_ASSERT_NXT(a_fill_dn, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

@@ design/lpg_front.sv @@
// ---------------------------------------------------------------------------
// lpg_front
// Accepts items, holds the line state, runs a Bresenham step per step item.
// ---------------------------------------------------------------------------
`include "line_pixel_generator_assert.svh"

module lpg_front import lpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PW         = 2 * COORD_BITS + 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [31:0]           i_color,
    input  logic                  i_fifo_full,
    output logic                  o_push,
    output logic [PW-1:0]         o_push_data
);

    localparam int EW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_end_x, n_end_x;
    logic [COORD_BITS-1:0] r_end_y, n_end_y;
    logic [COORD_BITS-1:0] r_dx,    n_dx;
    logic [COORD_BITS-1:0] r_dy,    n_dy;
    logic                  r_x_neg, n_x_neg;
    logic                  r_y_neg, n_y_neg;
    logic signed [EW-1:0]  r_err,   n_err;
    logic [31:0]           r_color, n_color;
    logic                  r_active, n_active;

    logic                  w_accept, w_load, w_step, w_is_last;
    logic [COORD_BITS-1:0] w_ld_dx, w_ld_dy;
    logic signed [EW-1:0]  w_dx_ext, w_dy_ext;
    logic                  w_move_x, w_move_y;

    assign o_in_ready = !i_fifo_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (i_opcode == OP_LOAD);
    assign w_step     = w_accept && (i_opcode == OP_STEP) && r_active;
    assign w_is_last  = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);

    // load: absolute deltas of the new line
    assign w_ld_dx = (i_x_end >= i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign w_ld_dy = (i_y_end >= i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;

    // step: error compares against the stored deltas
    assign w_dx_ext = $signed({2'b00, r_dx});
    assign w_dy_ext = $signed({2'b00, r_dy});
    assign w_move_x = (r_err > -w_dx_ext);
    assign w_move_y = (r_err < w_dy_ext);

    // pixel handed to the queue
    assign o_push      = w_step;
    assign o_push_data = {r_cur_x, r_cur_y, r_color, w_is_last};

    // next line state
    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_end_x  = r_end_x;
        n_end_y  = r_end_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_x_neg  = r_x_neg;
        n_y_neg  = r_y_neg;
        n_err    = r_err;
        n_color  = r_color;
        n_active = r_active;
        if (w_load) begin
            n_cur_x  = i_x_start;
            n_cur_y  = i_y_start;
            n_end_x  = i_x_end;
            n_end_y  = i_y_end;
            n_dx     = w_ld_dx;
            n_dy     = w_ld_dy;
            n_x_neg  = !(i_x_start < i_x_end);
            n_y_neg  = !(i_y_start < i_y_end);
            // half of the dominant term, rounded toward zero
            n_err    = (w_ld_dx > w_ld_dy) ? $signed({2'b00, w_ld_dx >> 1})
                                           : -$signed({2'b00, w_ld_dy >> 1});
            n_color  = i_color;
            n_active = 1'b1;
        end else if (w_step) begin
            if (w_is_last) begin
                n_active = 1'b0;
            end else begin
                n_err = r_err - (w_move_x ? w_dy_ext : EW'(0))
                              + (w_move_y ? w_dx_ext : EW'(0));
                if (w_move_x) begin
                    n_cur_x = r_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (w_move_y) begin
                    n_cur_y = r_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_end_x  <= '0;
            r_end_y  <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_x_neg  <= 1'b0;
            r_y_neg  <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_end_x  <= n_end_x;
            r_end_y  <= n_end_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_x_neg  <= n_x_neg;
            r_y_neg  <= n_y_neg;
            r_err    <= n_err;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

    `LPG_ASSERT_NXT(a_last_idles, i_clk, i_rst_n, w_step && w_is_last, !r_active)
    `LPG_ASSERT_NXT(a_load_arms, i_clk, i_rst_n, w_load, r_active && (r_cur_x == $past(i_x_start)))

endmodule

@@ design/lpg_back.sv @@
// ---------------------------------------------------------------------------
// lpg_back
// Turns queued pixels into byte addresses and packed pixel words.
// ---------------------------------------------------------------------------
`include "line_pixel_generator_assert.svh"

module lpg_back import lpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PW         = 2 * COORD_BITS + 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_fifo_valid,
    input  logic [PW-1:0]         i_fifo_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [31:0]           o_byte_address,
    output logic [31:0]           o_pixel_word,
    output logic                  o_last
);

    localparam int YW = COORD_BITS + 16;
    localparam int XW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] w_x, w_y;
    logic [31:0]           w_color;
    logic                  w_last;
    logic                  w_out_free, w_s1_free;

    // stage 1: products and packed word
    logic                  r_s1_valid;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic [YW-1:0]         r_s1_prod_y;
    logic [XW-1:0]         r_s1_prod_x;
    logic [31:0]           r_s1_word;
    logic                  r_s1_last;

    // stage 2: output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [31:0]           r_out_addr, r_out_word;
    logic                  r_out_last;

    assign {w_x, w_y, w_color, w_last} = i_fifo_data;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_pop      = i_fifo_valid && w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_fifo_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // row and column offsets, byte packing
    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_x      <= w_x;
            r_s1_y      <= w_y;
            r_s1_prod_y <= YW'(w_y * i_cfg.line_bytes);
            r_s1_prod_x <= XW'(w_x * i_cfg.bits_per_pixel[5:3]);
            r_s1_word   <= pack_pixel(w_color, i_cfg.bits_per_pixel, i_cfg.big_endian);
            r_s1_last   <= w_last;
        end
    end

    // final address sum, modulo 2^32
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_x    <= r_s1_x;
            r_out_y    <= r_s1_y;
            r_out_addr <= i_cfg.frame_base + 32'(r_s1_prod_y) + 32'(r_s1_prod_x);
            r_out_word <= r_s1_word;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_byte_address = r_out_addr;
    assign o_pixel_word   = r_out_word;
    assign o_last         = r_out_last;

    `LPG_ASSERT_NXT(a_s1_moves, i_clk, i_rst_n, r_s1_valid && w_out_free, r_out_valid)

endmodule

@@ design/line_pixel_generator.sv @@
// ---------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasterizer with frame-buffer byte addressing.
// A step item's pixel passes the queue, stage 1 and the output register.
// Throughput: one item per cycle unless the queue is full. The front steps
//   the line; back multiplies row/col offsets in stage 1, adds in stage 2.
// Reset (sync, active low): no line loaded, queue and pipeline empty,
//   registers at their reset values.
// ---------------------------------------------------------------------------
module line_pixel_generator import lpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [31:0]           i_color,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [31:0]           o_byte_address,
    output logic [31:0]           o_pixel_word,
    output logic                  o_last
);

    localparam int PW = 2 * COORD_BITS + 33;

    logic [31:0] r_frame_base;
    logic [15:0] r_line_bytes;
    logic [5:0]  r_bpp;
    logic        r_big_endian;
    logic        w_cfg_wr;
    t_reg_idx    w_reg_idx;
    t_cfg        w_cfg;

    logic          w_push, w_fifo_full, w_fifo_valid, w_pop;
    logic [PW-1:0] w_push_data, w_fifo_data;

    // register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= FRAME_BASE_RST;
            r_line_bytes <= LINE_BYTES_RST;
            r_bpp        <= BPP_RST;
            r_big_endian <= BIG_ENDIAN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_FRAME_BASE: r_frame_base <= pwdata;
                REG_LINE_BYTES: r_line_bytes <= pwdata[15:0];
                REG_BPP:        r_bpp        <= pwdata[5:0];
                REG_BIG_ENDIAN: r_big_endian <= pwdata[0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_reg_idx)
            REG_FRAME_BASE: prdata = r_frame_base;
            REG_LINE_BYTES: prdata = {16'd0, r_line_bytes};
            REG_BPP:        prdata = {26'd0, r_bpp};
            REG_BIG_ENDIAN: prdata = {31'd0, r_big_endian};
        endcase
    end

    assign w_cfg = '{frame_base:     r_frame_base,
                     line_bytes:     r_line_bytes,
                     bits_per_pixel: r_bpp,
                     big_endian:     r_big_endian};

    lpg_front #(
        .COORD_BITS (COORD_BITS),
        .PW         (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_color     (i_color),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    lpg_fifo #(
        .WIDTH (PW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_fifo_full),
        .o_valid     (w_fifo_valid),
        .o_data      (w_fifo_data),
        .i_pop       (w_pop)
    );

    lpg_back #(
        .COORD_BITS (COORD_BITS),
        .PW         (PW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_fifo_valid   (w_fifo_valid),
        .i_fifo_data    (w_fifo_data),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_pixel_word   (o_pixel_word),
        .o_last         (o_last)
    );

endmodule

@@ tb/line_pixel_generator_tb.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator_tb
// Self-checking bench for the Bresenham line pixel generator. A directed table
// covers degenerate lines, extreme corners, steps with no line and reloads of
// an active line. Random line sequences follow over several register settings
// and handshake idling phases. Every pixel is checked against a line predictor.
// ----------------------------------------------------------------------------
module line_pixel_generator_tb;
    import lpg_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 75;

    typedef struct packed {
        t_opcode     op;
        logic [11:0] x0;
        logic [11:0] y0;
        logic [11:0] x1;
        logic [11:0] y1;
        logic [31:0] color;
    } t_draw_cmd;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] addr;
        logic [31:0] word;
        logic        last;
    } t_pixel;

    typedef struct packed {
        t_draw_cmd cmd;
        bit        fixed_exp;
        t_pixel    px;
    } t_dir_row;

    localparam t_pixel NO_PIXEL = '0;

    // directed items; pixels typed in where they follow from reset registers
    // (base 0, 4800 bytes per row, 32 bits per pixel, little endian)
    localparam t_dir_row DIRECTED_ROWS [25] = '{
        // step with no line loaded
        '{'{OP_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF}, 1'b0, NO_PIXEL},
        // single-pixel line at the origin
        '{'{OP_LOAD, 12'd0, 12'd0, 12'd0, 12'd0, 32'h1122_3344}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd0, 12'd0, 32'd0, 32'h1122_3344, 1'b1}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        // single-pixel line at the far corner
        '{'{OP_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'hFFF, 12'hFFF, 32'd19672380, 32'hFFFF_FFFF, 1'b1}},
        // horizontal run
        '{'{OP_LOAD, 12'd0, 12'd0, 12'd3, 12'd0, 32'hA5C3_0F81}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd0, 12'd0, 32'd0, 32'hA5C3_0F81, 1'b0}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd1, 12'd0, 32'd4, 32'hA5C3_0F81, 1'b0}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd2, 12'd0, 32'd8, 32'hA5C3_0F81, 1'b0}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd3, 12'd0, 32'd12, 32'hA5C3_0F81, 1'b1}},
        // vertical run
        '{'{OP_LOAD, 12'd0, 12'd0, 12'd0, 12'd2, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd0, 12'd0, 32'd0, 32'h0, 1'b0}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd0, 12'd1, 32'd4800, 32'h0, 1'b0}},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b1,
          '{12'd0, 12'd2, 32'd9600, 32'h0, 1'b1}},
        // long anti-diagonal, cut short by a reload
        '{'{OP_LOAD, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 32'h5A5A_5A5A}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_LOAD, 12'd10, 12'd10, 12'd7, 12'd14, 32'h0102_0304}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL},
        // step after the line ended
        '{'{OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0}, 1'b0, NO_PIXEL}
    };

    // DUT signals
    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    logic [11:0] i_x_start;
    logic [11:0] i_y_start;
    logic [11:0] i_x_end;
    logic [11:0] i_y_end;
    logic [31:0] i_color;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_pixel_x;
    logic [11:0] o_pixel_y;
    logic [31:0] o_byte_address;
    logic [31:0] o_pixel_word;
    logic        o_last;

    // register shadow
    logic [31:0] cfg_base  = FRAME_BASE_RST;
    logic [15:0] cfg_pitch = LINE_BYTES_RST;
    logic [5:0]  cfg_bpp   = BPP_RST;
    logic        cfg_big   = BIG_ENDIAN_RST;

    // line walker state
    logic [11:0] pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
    logic [11:0] span_x = '0, span_y = '0;
    logic        x_back = 1'b0, y_back = 1'b0;
    int          err_acc = 0;
    logic [31:0] seg_color = '0;
    logic        drawing = 1'b0;

    t_pixel      pending_pixels[$];
    int          fail_count    = 0;
    int          counted_items = 0;
    int          src_idle_pct  = 0;
    int          rx_stall_pct  = 0;
    int          rx_hold_left  = 0;

    line_pixel_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_color        (i_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_pixel_word   (o_pixel_word),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // color bytes in write order, first byte in bits 7:0
    function automatic logic [31:0] pixel_bytes(input logic [31:0] c);
        int          n;
        int          sh;
        logic [31:0] w;
        n = int'(cfg_bpp >> 3);
        w = '0;
        for (int k = 0; k < 4 && k < n; k++) begin
            sh = cfg_big ? 8 * (n - 1 - k) : 8 * k;
            if (sh < 32) w[8*k +: 8] = 8'(c >> sh) & BYTE_MASK;
        end
        return w;
    endfunction

    // advance the line walker by one item; returns 1 when a pixel comes out
    function automatic bit rasterize(input t_draw_cmd c, output t_pixel px);
        int sx;
        int sy;
        int e2;
        px = NO_PIXEL;
        if (c.op == OP_LOAD) begin
            pos_x     = c.x0;
            pos_y     = c.y0;
            goal_x    = c.x1;
            goal_y    = c.y1;
            x_back    = !(c.x0 < c.x1);
            y_back    = !(c.y0 < c.y1);
            span_x    = (c.x1 >= c.x0) ? c.x1 - c.x0 : c.x0 - c.x1;
            span_y    = (c.y1 >= c.y0) ? c.y1 - c.y0 : c.y0 - c.y1;
            sx        = int'(span_x);
            sy        = int'(span_y);
            err_acc   = ((sx > sy) ? sx : -sy) / 2;
            seg_color = c.color;
            drawing   = 1'b1;
            return 1'b0;
        end
        if (!drawing) return 1'b0;
        px.x    = pos_x;
        px.y    = pos_y;
        px.addr = cfg_base + 32'(pos_y) * 32'(cfg_pitch) + 32'(pos_x) * 32'(cfg_bpp >> 3);
        px.word = pixel_bytes(seg_color);
        px.last = (pos_x == goal_x) && (pos_y == goal_y);
        if (px.last) begin
            drawing = 1'b0;
        end else begin
            sx = int'(span_x);
            sy = int'(span_y);
            e2 = err_acc;
            if (e2 > -sx) begin
                err_acc -= sy;
                pos_x = x_back ? pos_x - 12'd1 : pos_x + 12'd1;
            end
            if (e2 < sy) begin
                err_acc += sx;
                pos_y = y_back ? pos_y - 12'd1 : pos_y + 12'd1;
            end
        end
        return 1'b1;
    endfunction

    // compare one accepted pixel with the oldest expected one
    function automatic void check_pixel();
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected pixel x=%0d y=%0d addr=%h", o_pixel_x, o_pixel_y,
                         o_byte_address);
            return;
        end
        want = pending_pixels.pop_front();
        if (o_pixel_x !== want.x || o_pixel_y !== want.y || o_byte_address !== want.addr ||
            o_pixel_word !== want.word || o_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
                $display("pixel mismatch: exp x=%0d y=%0d addr=%h word=%h last=%b, ",
                         want.x, want.y, want.addr, want.word, want.last,
                         "got x=%0d y=%0d addr=%h word=%h last=%b",
                         o_pixel_x, o_pixel_y, o_byte_address, o_pixel_word, o_last);
        end
    endfunction

    function automatic t_draw_cmd random_cmd(input t_opcode op);
        t_draw_cmd c;
        c.op    = op;
        c.x0    = 12'($urandom);
        c.y0    = 12'($urandom);
        c.x1    = 12'($urandom);
        c.y1    = 12'($urandom);
        c.color = $urandom;
        return c;
    endfunction

    // move a coordinate by span, turning back at the edges
    function automatic logic [11:0] nudge(input logic [11:0] p, input int span);
        int v;
        v = $urandom_range(1) ? int'(p) + span : int'(p) - span;
        if (v > 4095) v = int'(p) - span;
        if (v < 0) v = int'(p) + span;
        return 12'(v);
    endfunction

    // receiver: check on accept, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_pixel();
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: ends the run after a long stretch with no handshake
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one item, wait for accept, then record its expected pixel
    task automatic send_cmd(input t_draw_cmd c, input bit fixed_exp, input t_pixel fixed_px);
        t_pixel px;
        bit     ignored;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= c.op;
        i_x_start  <= c.x0;
        i_y_start  <= c.y0;
        i_x_end    <= c.x1;
        i_y_end    <= c.y1;
        i_color    <= c.color;
        do @(posedge i_clk); while (!o_in_ready);
        ignored = (c.op == OP_STEP) && !drawing;
        if (rasterize(c, px)) pending_pixels.push_back(fixed_exp ? fixed_px : px);
        if (!ignored) counted_items++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers back to back, then release the bus
    task automatic program_regs(input logic [31:0] base, input logic [15:0] pitch,
                                input logic [5:0] bpp, input logic big);
        logic [31:0] vals [4];
        t_reg_idx    idx;
        vals = '{base, 32'(pitch), 32'(bpp), 32'(big)};
        for (int i = 0; i < 4; i++) begin
            idx = t_reg_idx'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= vals[i];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            case (idx)
                REG_FRAME_BASE: cfg_base  = vals[i];
                REG_LINE_BYTES: cfg_pitch = vals[i][15:0];
                REG_BPP:        cfg_bpp   = vals[i][5:0];
                REG_BIG_ENDIAN: cfg_big   = vals[i][0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random sequence: mostly a short line walked to its end
    task automatic draw_sequence();
        t_draw_cmd c;
        int        r;
        int        shape;
        int        dx;
        int        dy;
        int        len;
        int        steps;
        int        pick;
        r = $urandom_range(99);
        if (r < 85) begin
            c = random_cmd(OP_LOAD);
            if (r < 72) begin
                shape = $urandom_range(9);
                dx = (shape == 0 || shape == 1) ? 0 : $urandom_range(24);
                dy = (shape == 0 || shape == 2) ? 0 : (shape == 3 ? dx : $urandom_range(24));
                c.x1 = nudge(c.x0, dx);
                c.y1 = nudge(c.y0, dy);
                len = ((dx > dy) ? dx : dy) + 1;
                pick = $urandom_range(99);
                if (pick < 12)      steps = $urandom_range(1, len);
                else if (pick < 22) steps = len + $urandom_range(1, 2);
                else                steps = len;
            end else begin
                // long line from random end points, abandoned partway
                steps = $urandom_range(1, 24);
            end
            send_cmd(c, 1'b0, NO_PIXEL);
            repeat (steps) send_cmd(random_cmd(OP_STEP), 1'b0, NO_PIXEL);
        end else begin
            repeat ($urandom_range(1, 3))
                send_cmd(random_cmd(t_opcode'($urandom_range(1))), 1'b0, NO_PIXEL);
        end
    endtask

    // main sequence
    initial begin
        int          phase_start;
        bit          paused;
        logic [5:0]  bpp;
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= 1'b0;
        i_x_start   <= '0;
        i_y_start   <= '0;
        i_x_end     <= '0;
        i_y_end     <= '0;
        i_color     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset register values
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].fixed_exp, DIRECTED_ROWS[i].px);
        wait_drained();

        // random phases, registers rewritten while idle
        paused = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: program_regs(FRAME_BASE_RST, LINE_BYTES_RST, BPP_RST, BIG_ENDIAN_RST);
                1: program_regs(32'hFFFF_FFFF, 16'hFFFF, 6'd32, 1'b1);
                2: program_regs(32'h0, 16'h0, 6'd8, 1'b0);
                default: begin
                    bpp = $urandom_range(1) ? 6'(8 * $urandom_range(1, 4))
                                            : 6'($urandom_range(8, 32));
                    program_regs($urandom, 16'($urandom), bpp, 1'($urandom));
                end
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin src_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin src_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            // long receiver hold while the sender keeps pushing
            if (ph == 0) rx_hold_left = HOLD_CYCLES;
            phase_start = counted_items;
            while (counted_items - phase_start < PHASE_ITEMS) begin
                if (ph == 3 && !paused && counted_items - phase_start >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                draw_sequence();
            end
            wait_drained();
        end

        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
